// ===== design/pfc_pkg.sv =====
// shared widths, register indexes and divider handshake types for the pid force controller
`default_nettype none
package pfc_pkg;
	localparam int FORCE_W    = 16;
	localparam int ERR_W      = 17;
	localparam int ESUM_W     = 18;
	localparam int DT_W       = 16;
	localparam int GAIN_W     = 32;
	localparam int ALPHA_W    = 17;
	localparam int CAP_W      = 31;
	localparam int CMD_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int FRAC_W     = 16;
	localparam int DIV_W      = 20;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam int DERIV_W    = 48;
	localparam int DERIV_HALF = DERIV_W / 2;
	localparam int INT_W      = 32;
	localparam int INT_SUM_W  = 37;
	localparam int D_W        = 51;
	localparam int SUM_W      = 68;
	localparam int SETTLE_W   = 22;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = ALPHA_W'(65536);
	localparam logic [DERIV_W-1:0] DERIV_MAX     = {1'b0, {(DERIV_W-1){1'b1}}};
	localparam logic [4:0]         SETTLE_FACTOR = 5'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_I    = 3'd1,
		CFG_GAIN_D    = 3'd2,
		CFG_ALPHA     = 3'd3,
		CFG_INT_CAP   = 3'd4,
		CFG_CMD_LIMIT = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic             rem_nz;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== design/pfc_ifs.sv =====
// valid/ready channel interfaces for the controller's input and result items
`default_nettype none
interface pfc_req_if import pfc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] desired_force;
	logic signed [FORCE_W-1:0] measured_force;
	logic [DT_W-1:0]           elapsed_time;
	logic                      restart;

	modport source (output valid, desired_force, measured_force, elapsed_time, restart,
		input ready);
	modport sink (input valid, desired_force, measured_force, elapsed_time, restart,
		output ready);
endinterface

interface pfc_rsp_if import pfc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] force_error;
	logic signed [CMD_W-1:0] velocity_command;
	logic                    settled;

	modport source (output valid, force_error, velocity_command, settled, input ready);
	modport sink (input valid, force_error, velocity_command, settled, output ready);
endinterface
`default_nettype wire

// ===== design/pid_force_controller_unit.sv =====
// pid force controller: sequencer, state and clamps around a shared multiplier and divider
//
// usage
//   req channel (valid/ready) carries desired_force, measured_force, elapsed_time and
//   restart; rsp channel (valid/ready) returns force_error, velocity_command and settled.
//   gains, derivative alpha and both clamps are written through cfg_we/cfg_index/cfg_data
//   while no item is in flight.
// sequencing
//   each item passes eight times through the shared 33x33 multiplier and once through
//   the 20-step serial divider for the derivative division by elapsed time. req.ready
//   is high only while the sequencer is idle, so a new item is not taken until the last
//   one has left the sequencer.
// reset
//   arst_n clears the controller state (previous error, integral, filtered derivative,
//   settled flag), loads the register reset values and empties the result register.
// stalls
//   the result sits in an output register; a new item is accepted while it waits. if
//   rsp.ready stays low, the next item holds in its final step until the register frees.
`default_nettype none
module pid_force_controller_unit import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	pfc_req_if.sink               req,
	pfc_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_TRAP = 13'b0000000000010,
		S_DIFF = 13'b0000000000100,
		S_AH   = 13'b0000000001000,
		S_AL   = 13'b0000000010000,
		S_ASUM = 13'b0000000100000,
		S_WDIV = 13'b0000001000000,
		S_KP   = 13'b0000010000000,
		S_KI   = 13'b0000100000000,
		S_KD   = 13'b0001000000000,
		S_KL   = 13'b0010000000000,
		S_FIN  = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [ALPHA_W-1:0]       alpha_q;
	logic [CAP_W-1:0]         int_cap_q, cmd_limit_q;

	logic signed [ERR_W-1:0]   prev_q;
	logic signed [INT_W-1:0]   integral_q;
	logic signed [DERIV_W-1:0] fd_q;
	logic                      settled_q;

	logic signed [ERR_W-1:0]   e_q;
	logic [FORCE_W:0]          ad_q;
	logic [DT_W-1:0]           dt_q;
	logic                      xneg_q;
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]   sum_q;

	logic signed [ERR_W-1:0]  force_error_q;
	logic signed [CMD_W-1:0]  velocity_q;
	logic                     settled_out_q;
	logic                     out_valid_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	logic [ALPHA_W-1:0]        alpha_eff;
	logic [ALPHA_W:0]          alpha_fac;
	logic signed [ESUM_W-1:0]  esum, ediff;
	logic signed [ERR_W-1:0]   e_new;
	logic signed [INT_SUM_W-1:0] int_sum, cap_s;
	logic signed [DIV_W-1:0]   x_div;
	logic [DIV_W:0]            q_adj;
	logic signed [DIV_W:0]     t1;
	logic signed [D_W-1:0]     d_val, dmax_s;
	logic signed [SUM_W-1:0]   lim_s;
	logic [ERR_W-1:0]          ae;
	logic [SETTLE_W-1:0]       ae20;
	logic                      out_free, load_out;

	pfc_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_s1(prod_s1));
	pfc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_fac = {1'b0, alpha_eff} + {1'b0, ALPHA_ONE};
	assign esum      = ESUM_W'(e_q) + ESUM_W'(prev_q);
	assign ediff     = ESUM_W'(e_q) - ESUM_W'(prev_q);
	assign e_new     = ERR_W'(req.measured_force) - ERR_W'(req.desired_force);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TRAP: begin
				mul_a = MUL_W'({1'b0, dt_q});
				mul_b = MUL_W'(esum);
			end
			S_DIFF: begin
				mul_a = MUL_W'({1'b0, alpha_fac});
				mul_b = MUL_W'(ediff);
			end
			S_AH: begin
				mul_a = MUL_W'({1'b0, alpha_eff});
				mul_b = MUL_W'($signed(fd_q[DERIV_W-1:DERIV_HALF]));
			end
			S_AL: begin
				mul_a = MUL_W'({1'b0, alpha_eff});
				mul_b = MUL_W'({1'b0, fd_q[DERIV_HALF-1:0]});
			end
			S_KP: begin
				mul_a = MUL_W'(gain_p_q);
				mul_b = MUL_W'(e_q);
			end
			S_KI: begin
				mul_a = MUL_W'(gain_i_q);
				mul_b = MUL_W'(integral_q);
			end
			S_KD: begin
				mul_a = MUL_W'(gain_d_q);
				mul_b = MUL_W'($signed(fd_q[DERIV_W-1:FRAC_W]));
			end
			S_KL: begin
				mul_a = MUL_W'(gain_d_q);
				mul_b = MUL_W'({1'b0, fd_q[FRAC_W-1:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// trapezoid step and integral clamp
	assign int_sum = INT_SUM_W'(integral_q) + INT_SUM_W'($signed(prod_s1[INT_SUM_W-1:1]));
	assign cap_s   = INT_SUM_W'({1'b0, int_cap_q});

	// derivative division by elapsed time
	assign x_div            = prod_s1[DIV_W+FRAC_W-1:FRAC_W];
	assign div_req.start    = (state_q == S_AH);
	assign div_req.dividend = x_div[DIV_W-1] ? DIV_W'(-x_div) : DIV_W'(x_div);
	assign div_req.divisor  = dt_q;
	assign q_adj  = {1'b0, div_rsp.quotient} + (DIV_W+1)'(xneg_q && div_rsp.rem_nz);
	assign t1     = xneg_q ? -$signed(q_adj) : $signed(q_adj);
	assign d_val  = D_W'(t1) - D_W'($signed(acc_q[PROD_W-1:FRAC_W]));
	assign dmax_s = D_W'(DERIV_MAX);

	assign lim_s = SUM_W'({1'b0, cmd_limit_q});
	assign ae    = e_q[ERR_W-1] ? ERR_W'(-e_q) : ERR_W'(e_q);
	assign ae20  = SETTLE_W'(ae) * SETTLE_W'(SETTLE_FACTOR);

	assign out_free = !out_valid_q || rsp.ready;
	assign load_out = (state_q == S_OUT) && out_free;
	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			alpha_q     <= '0;
			int_cap_q   <= '1;
			cmd_limit_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_GAIN_P:    gain_p_q    <= cfg_data;
				CFG_GAIN_I:    gain_i_q    <= cfg_data;
				CFG_GAIN_D:    gain_d_q    <= cfg_data;
				CFG_ALPHA:     alpha_q     <= cfg_data[ALPHA_W-1:0];
				CFG_INT_CAP:   int_cap_q   <= cfg_data[CAP_W-1:0];
				CFG_CMD_LIMIT: cmd_limit_q <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			integral_q  <= '0;
			fd_q        <= '0;
			settled_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.restart) begin
							prev_q     <= '0;
							integral_q <= '0;
							fd_q       <= '0;
							settled_q  <= 1'b0;
						end
						state_q <= S_TRAP;
					end
				end
				S_TRAP: state_q <= S_DIFF;
				S_DIFF: begin
					if (int_sum > cap_s) begin
						integral_q <= INT_W'(cap_s);
					end else if (int_sum < -cap_s) begin
						integral_q <= INT_W'(-cap_s);
					end else begin
						integral_q <= INT_W'(int_sum);
					end
					state_q <= S_AH;
				end
				S_AH:   state_q <= S_AL;
				S_AL:   state_q <= S_ASUM;
				S_ASUM: state_q <= S_WDIV;
				S_WDIV: begin
					if (div_rsp.done) begin
						if (d_val > dmax_s) begin
							fd_q <= DERIV_MAX;
						end else if (d_val < -dmax_s) begin
							fd_q <= DERIV_W'(-dmax_s);
						end else begin
							fd_q <= DERIV_W'(d_val);
						end
						state_q <= S_KP;
					end
				end
				S_KP:  state_q <= S_KI;
				S_KI:  state_q <= S_KD;
				S_KD:  state_q <= S_KL;
				S_KL:  state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						settled_q <= settled_q || (ae20 < SETTLE_W'(ad_q));
						prev_q    <= e_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				e_q  <= e_new;
				ad_q <= req.desired_force[FORCE_W-1] ? -(FORCE_W+1)'(req.desired_force)
					: (FORCE_W+1)'(req.desired_force);
				dt_q <= (req.elapsed_time == '0) ? DT_W'(1) : req.elapsed_time;
			end
			S_AH: xneg_q <= x_div[DIV_W-1];
			S_AL: acc_q <= {prod_s1[PROD_W-DERIV_HALF-1:0], {DERIV_HALF{1'b0}}};
			S_ASUM: acc_q <= acc_q + prod_s1;
			S_KI: sum_q <= SUM_W'($signed(prod_s1[PROD_W-1:FRAC_W]));
			S_KD: sum_q <= sum_q + SUM_W'($signed(prod_s1[PROD_W-1:FRAC_W]));
			S_KL: sum_q <= sum_q + SUM_W'(prod_s1);
			S_FIN: sum_q <= sum_q + SUM_W'($signed(prod_s1[PROD_W-1:FRAC_W]));
			default: ;
		endcase
		if (load_out) begin
			force_error_q <= e_q;
			settled_out_q <= settled_q || (ae20 < SETTLE_W'(ad_q));
			if (sum_q > lim_s) begin
				velocity_q <= CMD_W'(lim_s);
			end else if (sum_q < -lim_s) begin
				velocity_q <= CMD_W'(-lim_s);
			end else begin
				velocity_q <= CMD_W'(sum_q);
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.force_error      = force_error_q;
	assign rsp.velocity_command = velocity_q;
	assign rsp.settled          = settled_out_q;
endmodule
`default_nettype wire

// ===== design/pfc_mul.sv =====
// shared signed multiplier with a registered product
`default_nettype none
module pfc_mul import pfc_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [PROD_W-1:0] prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end
endmodule
`default_nettype wire

// ===== design/pfc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module pfc_div import pfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [DT_W-1:0]      rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DT_W-1:0]      divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DT_W:0]        trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= DIV_CNT_W'(DIV_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DT_W'(trial - {1'b0, divisor_q});
			end else begin
				rem_q <= trial[DT_W-1:0];
			end
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = |rem_q;
endmodule
`default_nettype wire

// ===== design/pfc_checker.sv =====
// port-level checks on the pid force controller, bound to the top level
`default_nettype none
module pfc_checker import pfc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic signed [ERR_W-1:0] rsp_force_error,
	input logic signed [CMD_W-1:0] rsp_velocity_command,
	input logic                    rsp_settled
);
	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken again right after an item");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while sequencer was idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_error)
			&& $stable(rsp_velocity_command) && $stable(rsp_settled))
		else $error("stalled result changed");
endmodule

bind pid_force_controller_unit pfc_checker u_pfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_force_error(rsp.force_error),
	.rsp_velocity_command(rsp.velocity_command),
	.rsp_settled(rsp.settled)
);
`default_nettype wire
